// File: hdl/bls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

   localparam int DEPTH  = 8;
   localparam int DATA_W = 32;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_DUMP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_READ,
      CS_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_TOP,
      RD_FIRST,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_HOLD,
      RES_IMM,
      RES_READ
   } res_sel_type;

   typedef struct packed {
      logic        latch_op;
      logic        push_write;
      logic        cnt_inc;
      logic        cnt_dec;
      rd_sel_type  rd_sel;
      res_sel_type res_sel;
      status_type  imm_status;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type req_op;
      logic       full;
      logic       empty;
      logic       out_last;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: hdl/bls_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface bls_req_if;
   logic                            valid;
   logic                            ready;
   bls_pkg::opcode_type             opcode;
   logic signed [bls_pkg::DATA_W-1:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface bls_rsp_if;
   logic                            valid;
   logic                            ready;
   bls_pkg::status_type             status;
   logic signed [bls_pkg::DATA_W-1:0] data;
   logic                            last;

   modport source (output valid, output status, output data, output last, input ready);
   modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/bls_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bls_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bls_pkg::dp_cmd_type               cmd,
   output bls_pkg::dp_stat_type                   stat,
   input  wire bls_pkg::opcode_type               req_opcode,
   input  wire logic signed [bls_pkg::DATA_W-1:0] req_push_value,
   output bls_pkg::status_type                    rsp_status,
   output logic signed [bls_pkg::DATA_W-1:0]      rsp_data,
   output logic                                   rsp_last
);
   import bls_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic              dump_ff, dump_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;

   logic [CNT_W-1:0]  cnt_m1;
   logic [PTR_W-1:0]  rd_addr;
   logic              rd_en;
   logic              full;
   logic              empty;
   logic              dump_last;

   assign cnt_m1    = cnt_ff - CNT_W'(1);
   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign empty     = (cnt_ff == '0);
   assign dump_last = (CNT_W'(idx_ff) == cnt_m1);

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = idx_ff;
      idx_in  = idx_ff;
      unique case (cmd.rd_sel)
         RD_NONE: begin
            rd_en = 1'b0;
         end
         RD_TOP: begin
            rd_addr = PTR_W'(cnt_m1);
         end
         RD_FIRST: begin
            rd_addr = '0;
            idx_in  = '0;
         end
         RD_NEXT: begin
            rd_addr = idx_ff + PTR_W'(1);
            idx_in  = idx_ff + PTR_W'(1);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_m1;
      end
   end

   assign dump_in = cmd.latch_op ? (req_opcode == OP_DUMP) : dump_ff;

   always_comb begin
      status_in = status_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      unique case (cmd.res_sel)
         RES_HOLD: begin
         end
         RES_IMM: begin
            status_in = cmd.imm_status;
            data_in   = '0;
            last_in   = 1'b1;
         end
         RES_READ: begin
            status_in = STAT_OK;
            data_in   = rd_data_ff;
            last_in   = !dump_ff || dump_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      dump_ff   <= dump_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

   // stack storage, written at the fill count, read one address per cycle when a read is selected
   always_ff @(posedge clock) begin
      if (cmd.push_write) begin
         mem[PTR_W'(cnt_ff)] <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign stat.req_op   = req_opcode;
   assign stat.full     = full;
   assign stat.empty    = empty;
   assign stat.out_last = last_ff;

   assign rsp_status = status_ff;
   assign rsp_data   = data_ff;
   assign rsp_last   = last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push_write |-> !full && cmd.cnt_inc)
      else $error("write into a full stack");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
      else $error("pop did not drop the fill count");

endmodule

`default_nettype wire

// File: hdl/bls_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module bls_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire bls_pkg::dp_stat_type stat,
   output bls_pkg::dp_cmd_type       cmd
);
   import bls_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd.latch_op   = 1'b0;
      cmd.push_write = 1'b0;
      cmd.cnt_inc    = 1'b0;
      cmd.cnt_dec    = 1'b0;
      cmd.rd_sel     = RD_NONE;
      cmd.res_sel    = RES_HOLD;
      cmd.imm_status = STAT_OK;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_op = 1'b1;
               if (stat.req_op == OP_PUSH) begin
                  cmd.res_sel = RES_IMM;
                  state_in    = CS_OUT;
                  if (stat.full) begin
                     cmd.imm_status = STAT_OVERFLOW;
                  end else begin
                     cmd.push_write = 1'b1;
                     cmd.cnt_inc    = 1'b1;
                  end
               end else if (stat.empty) begin
                  cmd.res_sel    = RES_IMM;
                  cmd.imm_status = STAT_EMPTY;
                  state_in       = CS_OUT;
               end else begin
                  state_in = CS_READ;
                  unique case (stat.req_op)
                     OP_POP: begin
                        cmd.rd_sel  = RD_TOP;
                        cmd.cnt_dec = 1'b1;
                     end
                     OP_PEEK: begin
                        cmd.rd_sel = RD_TOP;
                     end
                     default: begin
                        cmd.rd_sel = RD_FIRST;
                     end
                  endcase
               end
            end
         end
         CS_READ: begin
            cmd.res_sel = RES_READ;
            state_in    = CS_OUT;
         end
         CS_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               // a dump walks on to the next entry until the top beat is taken
               if (stat.out_last) begin
                  state_in = CS_IDLE;
               end else begin
                  cmd.rd_sel = RD_NEXT;
                  state_in   = CS_READ;
               end
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   a_read_then_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_READ) |=> (state_ff == CS_OUT))
      else $error("read not followed by a result");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

endmodule

`default_nettype wire

// File: hdl/bounded_lifo_stack_top.sv
`timescale 1ns / 1ps
`default_nettype none

// response: push and every error status give their beat in the cycle after accept;
//   pop and peek pass the registered memory read and then the result register
// flow: no new request is taken until each result beat is taken; a dump reads
//   its entries one by one through the one memory read port
// reset: synchronous, active high; clears the fill count and controller state,
//   stored entries stay undefined until written

module bounded_lifo_stack_top (
   input wire logic   clock,
   input wire logic   reset,
   bls_req_if.sink    req_chan,
   bls_rsp_if.source  rsp_chan
);
   import bls_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bls_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bls_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_chan.opcode),
      .req_push_value (req_chan.push_value),
      .rsp_status     (rsp_chan.status),
      .rsp_data       (rsp_chan.data),
      .rsp_last       (rsp_chan.last)
   );

endmodule

`default_nettype wire

// File: tb/bounded_lifo_stack_top_tb.sv
`timescale 1ns / 1ps

module bounded_lifo_stack_top_tb;

   import bls_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } stack_result_type;

   logic clock;
   logic reset;

   bls_req_if req_chan ();
   bls_rsp_if rsp_chan ();

   bounded_lifo_stack_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the stack, updated at each accepted request beat
   logic signed [DATA_W-1:0] shadow_entries [DEPTH];
   int                       shadow_fill;
   stack_result_type         pending_results [$];

   int   mismatch_count;
   int   idle_cycles;
   int   req_gap_pct;
   int   rsp_stall_pct;
   int   rsp_stall_left;
   int   rsp_hold_left;
   logic rsp_ready_next;

   always #2 clock = ~clock;

   function automatic int idle_length(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(DATA_W-1){1'b0}}};
         1: return {1'b0, {(DATA_W-1){1'b1}}};
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_result(input status_type st,
                                        input logic signed [DATA_W-1:0] value,
                                        input logic is_last);
      stack_result_type r;
      r.status = st;
      r.data   = value;
      r.last   = is_last;
      pending_results.push_back(r);
   endfunction

   function automatic void predict_stack_op(input opcode_type op,
                                            input logic signed [DATA_W-1:0] value);
      if (op == OP_PUSH) begin
         if (shadow_fill >= DEPTH) begin
            queue_result(STAT_OVERFLOW, '0, 1'b1);
         end else begin
            shadow_entries[shadow_fill] = value;
            shadow_fill++;
            queue_result(STAT_OK, '0, 1'b1);
         end
      end else if (shadow_fill == 0) begin
         queue_result(STAT_EMPTY, '0, 1'b1);
      end else begin
         case (op)
            OP_POP: begin
               shadow_fill--;
               queue_result(STAT_OK, shadow_entries[shadow_fill], 1'b1);
            end
            OP_PEEK: begin
               queue_result(STAT_OK, shadow_entries[shadow_fill-1], 1'b1);
            end
            default: begin
               for (int i = 0; i < shadow_fill; i++)
                  queue_result(STAT_OK, shadow_entries[i], (i == shadow_fill - 1));
            end
         endcase
      end
   endfunction

   // valid stays high across back-to-back beats, only dropped for a gap
   task automatic send_beat(input opcode_type op, input logic signed [DATA_W-1:0] value);
      int gap;
      gap = idle_length(req_gap_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.push_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      predict_stack_op(op, value);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_cases();
      send_beat(OP_POP, $urandom);
      send_beat(OP_PEEK, $urandom);
      send_beat(OP_DUMP, $urandom);
      send_beat(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
      send_beat(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(OP_PUSH, '1);
      send_beat(OP_PUSH, '0);
      send_beat(OP_PUSH, 32'hAAAA_AAAA);
      send_beat(OP_PUSH, 32'h5555_5555);
      send_beat(OP_PUSH, $urandom);
      for (int i = 7; i < DEPTH; i++) send_beat(OP_PUSH, $urandom);
      // full stack, pushed value must be dropped
      send_beat(OP_PUSH, 32'h1234_5678);
      send_beat(OP_PEEK, $urandom);
      send_beat(OP_DUMP, $urandom);
      for (int i = 0; i < DEPTH; i++) send_beat(OP_POP, $urandom);
      send_beat(OP_POP, $urandom);
      drop_valid();
   endtask

   task automatic test_random_traffic(input int n_items);
      int push_pct;
      int pick;
      opcode_type op;
      push_pct = 50;
      for (int k = 0; k < n_items; k++) begin
         // phases that drift the fill level up or down so full and empty get hit
         if (k % 40 == 0) push_pct = $urandom_range(15, 85);
         if ($urandom_range(0, 99) < push_pct) begin
            op = OP_PUSH;
         end else begin
            pick = $urandom_range(0, 9);
            op = (pick < 5) ? OP_POP : (pick < 8) ? OP_PEEK : OP_DUMP;
         end
         send_beat(op, random_value());
      end
      drop_valid();
   endtask

   task automatic test_output_backpressure();
      req_gap_pct = 0;
      // receiver stalls for a long stretch while requests keep coming
      rsp_hold_left = 300;
      for (int k = 0; k < 40; k++)
         send_beat(($urandom_range(0, 3) == 0) ? OP_DUMP : opcode_type'($urandom_range(0, 2)),
                   random_value());
      drop_valid();
   endtask

   task automatic test_drain_pause();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      for (int k = 0; k < 10; k++) send_beat(opcode_type'($urandom_range(0, 3)), $urandom);
      drop_valid();
      wait_drained();
      for (int k = 0; k < 10; k++) send_beat(opcode_type'($urandom_range(0, 3)), $urandom);
      drop_valid();
   endtask

   task automatic test_back_to_back();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      for (int k = 0; k < DEPTH; k++) send_beat(OP_PUSH, $urandom);
      for (int k = 0; k < 30; k++)
         send_beat(($urandom_range(0, 2) == 0) ? OP_DUMP : opcode_type'($urandom_range(0, 2)),
                   $urandom);
      drop_valid();
   endtask

   // receiver side idling
   always @(negedge clock) begin
      rsp_ready_next = 1'b1;
      if (rsp_hold_left > 0) begin
         rsp_ready_next = 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall_left > 0) begin
         rsp_ready_next = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_stall_left = idle_length(rsp_stall_pct);
         if (rsp_stall_left > 0) begin
            rsp_ready_next = 1'b0;
            rsp_stall_left--;
         end
      end
      rsp_chan.ready <= rsp_ready_next;
   end

   always @(posedge clock) begin
      stack_result_type exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: status %0d data %0d last %0b",
                        rsp_chan.status, rsp_chan.data, rsp_chan.last);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_chan.status !== exp_r.status || rsp_chan.data !== exp_r.data ||
                rsp_chan.last !== exp_r.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected status %0d data %0d last %0b, got %0d %0d %0b",
                           exp_r.status, exp_r.data, exp_r.last,
                           rsp_chan.status, rsp_chan.data, rsp_chan.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_PUSH;
      req_chan.push_value = '0;
      rsp_chan.ready      = 1'b0;
      shadow_fill         = 0;
      mismatch_count      = 0;
      idle_cycles         = 0;
      req_gap_pct         = 20;
      rsp_stall_pct       = 20;
      rsp_stall_left      = 0;
      rsp_hold_left       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_cases();
      test_random_traffic(150);
      test_output_backpressure();
      req_gap_pct   = 25;
      rsp_stall_pct = 25;
      test_random_traffic(150);
      test_drain_pause();
      test_back_to_back();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
